### rtl/ecal_pkg.sv
// Package for the epoch to calendar converter: field widths, calendar
// constants, reciprocal constants for the constant divisions and the stage type.
// No dependencies.
`default_nettype none

package ecal_pkg;

    // Field widths
    localparam int EPOCH_W   = 32;
    localparam int YEAR_W    = 12;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int WEEKDAY_W = 3;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;

    // Pipeline depth; the last stage is the output register
    localparam int NUM_STAGES = 11;

    // Calendar constants
    localparam int DAYS_TO_ERA0     = 719468;
    localparam int DAYS_PER_ERA     = 146097;
    localparam int DAYS_PER_4Y      = 1460;
    localparam int DAYS_PER_100Y    = 36524;
    localparam int LAST_DAY_OF_ERA  = 146096;
    localparam int DAYS_PER_YEAR    = 365;
    localparam int DAYS_PER_5MONTHS = 153;
    localparam int YEARS_PER_ERA    = 400;
    localparam int SECS_PER_HOUR    = 3600;
    localparam int SECS_PER_MINUTE  = 60;
    localparam int DAYS_PER_WEEK    = 7;
    localparam int WEEKDAY_OF_EPOCH = 4;
    localparam int MARCH_MONTHS     = 10;  // March..December in the shifted year
    localparam int MONTH_OFS_UP     = 3;
    localparam int MONTH_OFS_DOWN   = 9;
    localparam int FEBRUARY         = 2;

    // 86400 = 675 << 7: the low 7 bits bypass the divider
    localparam int DAY_LO_BITS = 7;
    localparam int DAY_DIV     = 675;

    // Era 4 or era 5 covers the whole 32-bit input range
    localparam int ERA4_START = 4 * DAYS_PER_ERA;
    localparam int ERA5_START = 5 * DAYS_PER_ERA;
    localparam int ERA4_YEAR  = 4 * YEARS_PER_ERA;
    localparam int ERA5_YEAR  = 5 * YEARS_PER_ERA;

    // Floor reciprocals, scaled by 2^N where N is the dividend width.
    // The estimate is then exact or one low; one compare fixes it.
    localparam logic [15:0] DAY_RECIP  = 16'((64'd1 << 25) / 64'd675);
    localparam logic [13:0] WEEK_RECIP = 14'((64'd1 << 16) / 64'd7);
    localparam logic [5:0]  HOUR_RECIP = 6'((64'd1 << 17) / 64'd3600);
    localparam logic [6:0]  MIN_RECIP  = 7'((64'd1 << 12) / 64'd60);
    localparam logic [7:0]  Q4Y_RECIP  = 8'((64'd1 << 18) / 64'd1460);
    localparam logic [9:0]  YEAR_RECIP = 10'((64'd1 << 18) / 64'd365);
    localparam logic [3:0]  MP_RECIP   = 4'((64'd1 << 11) / 64'd153);

    // Everything one item carries through the pipeline
    typedef struct packed {
        logic [31:0] t;
        logic [15:0] days_est;
        logic [15:0] days;
        logic [16:0] sod;
        logic        era5;
        logic [17:0] doe;
        logic [13:0] wd_est;
        logic [2:0]  weekday;
        logic [5:0]  hour_est;
        logic [4:0]  hour;
        logic [11:0] rem;
        logic [7:0]  q4y_est;
        logic [2:0]  cent;
        logic        last;
        logic [17:0] n;
        logic [6:0]  min_est;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  yoe_est;
        logic [8:0]  yoe;
        logic [8:0]  doy;
        logic [10:0] mx;
        logic [3:0]  mp_est;
        logic [3:0]  mp;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } ecal_stage_t;

    // First day of each March-based month within the shifted year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

`default_nettype wire

### rtl/ecal_in_if.sv
// Input channel of the epoch to calendar converter: one timestamp per item.
// Depends on ecal_pkg for the field width.
`default_nettype none

interface ecal_in_if
    import ecal_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [EPOCH_W-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

`default_nettype wire

### rtl/ecal_out_if.sv
// Output channel of the epoch to calendar converter: one calendar date and time per item.
// Depends on ecal_pkg for the field widths.
`default_nettype none

interface ecal_out_if
    import ecal_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [WEEKDAY_W-1:0] weekday;
    logic [HOUR_W-1:0]    hour;
    logic [MINUTE_W-1:0]  minute;
    logic [SECOND_W-1:0]  second;

    modport source (output valid, output year, output month, output day, output weekday,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day, input weekday,
                    input hour, input minute, input second, output ready);
endinterface

`default_nettype wire

### rtl/epoch_to_calendar.sv
// Converts Unix seconds into a Gregorian date, weekday and time of day.
// Depends on ecal_pkg, ecal_in_if and ecal_out_if.
//
// Usage:
//   stamp carries one 32-bit count of seconds since 1970-01-01 00:00:00 per item.
//   date returns year, month, day, weekday (0 = Sunday), hour, minute, second.
//   Every input value is legal; years run 1970 to 2106.
// Timing:
//   11-stage pipeline, the last stage being the output register. An item
//   accepted from stamp moves through stages 0 to 10 in order, and one item is
//   taken every cycle in which stamp.ready is high. Each constant division is a
//   reciprocal multiply in one stage and a one-step remainder correction in
//   the next, which sets the stage count.
// Flow control:
//   Valid bits travel with the data. When date.ready is low, the stages fill
//   from the output backward, bubbles are squeezed out, and stamp.ready drops
//   only once every stage holds an item. Nothing is lost or repeated.
// Reset:
//   rst_n clears all valid bits; payload registers are not reset.
`default_nettype none

module epoch_to_calendar
    import ecal_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    ecal_in_if.sink     stamp,
    ecal_out_if.source  date
);

    localparam int LAST = NUM_STAGES - 1;

    ecal_stage_t             st_reg  [NUM_STAGES];
    ecal_stage_t             st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]   vld_reg;
    logic [NUM_STAGES-1:0]   vld_in;
    logic [NUM_STAGES:0]     stage_rdy;

    // Stage 0: day count estimate from the upper 25 bits
    logic [40:0] s0_prod;
    assign s0_prod = 41'(stamp.epoch_seconds[31:DAY_LO_BITS]) * 41'(DAY_RECIP);

    // Stage 1: fix the day count, form seconds of day
    logic [24:0] s1_rem;
    logic        s1_fix;
    logic [24:0] s1_rfix;
    assign s1_rem  = st_reg[0].t[31:DAY_LO_BITS]
                     - 25'(st_reg[0].days_est) * 25'(DAY_DIV);
    assign s1_fix  = s1_rem >= 25'(DAY_DIV);
    assign s1_rfix = s1_fix ? s1_rem - 25'(DAY_DIV) : s1_rem;

    // Stage 2: era and day of era; weekday and hour estimates
    logic [19:0] s2_z;
    logic        s2_era5;
    logic [19:0] s2_doe;
    logic [15:0] s2_wdx;
    logic [29:0] s2_wd_prod;
    logic [22:0] s2_hr_prod;
    assign s2_z       = 20'(st_reg[1].days) + 20'(DAYS_TO_ERA0);
    assign s2_era5    = s2_z >= 20'(ERA5_START);
    assign s2_doe     = s2_z - (s2_era5 ? 20'(ERA5_START) : 20'(ERA4_START));
    assign s2_wdx     = st_reg[1].days + 16'(WEEKDAY_OF_EPOCH);
    assign s2_wd_prod = 30'(s2_wdx) * 30'(WEEK_RECIP);
    assign s2_hr_prod = 23'(st_reg[1].sod) * 23'(HOUR_RECIP);

    // Stage 3: 4-year estimate, century count; fix weekday and hour
    logic [25:0] s3_q_prod;
    logic [17:0] s3_doe;
    logic [15:0] s3_wd_r;
    logic [16:0] s3_hr_r;
    logic        s3_hr_fix;
    assign s3_doe    = st_reg[2].doe;
    assign s3_q_prod = 26'(s3_doe) * 26'(Q4Y_RECIP);
    assign s3_wd_r   = (st_reg[2].days + 16'(WEEKDAY_OF_EPOCH))
                       - 16'(st_reg[2].wd_est) * 16'(DAYS_PER_WEEK);
    assign s3_hr_r   = st_reg[2].sod - 17'(st_reg[2].hour_est) * 17'(SECS_PER_HOUR);
    assign s3_hr_fix = s3_hr_r >= 17'(SECS_PER_HOUR);

    // Stage 4: fix 4-year count, form year-of-era numerator; minute estimate
    logic [17:0] s4_r;
    logic [7:0]  s4_q4y;
    logic [18:0] s4_min_prod;
    assign s4_r        = st_reg[3].doe - 18'(st_reg[3].q4y_est) * 18'(DAYS_PER_4Y);
    assign s4_q4y      = st_reg[3].q4y_est + 8'(s4_r >= 18'(DAYS_PER_4Y));
    assign s4_min_prod = 19'(st_reg[3].rem) * 19'(MIN_RECIP);

    // Stage 5: year-of-era estimate; fix minute
    logic [27:0] s5_yoe_prod;
    logic [11:0] s5_min_r;
    logic        s5_min_fix;
    assign s5_yoe_prod = 28'(st_reg[4].n) * 28'(YEAR_RECIP);
    assign s5_min_r    = st_reg[4].rem - 12'(st_reg[4].min_est) * 12'(SECS_PER_MINUTE);
    assign s5_min_fix  = s5_min_r >= 12'(SECS_PER_MINUTE);

    // Stage 6: fix year of era
    logic [17:0] s6_r;
    assign s6_r = st_reg[5].n - 18'(st_reg[5].yoe_est) * 18'(DAYS_PER_YEAR);

    // Stage 7: day of year
    logic [8:0]  s7_yoe;
    logic [1:0]  s7_c100;
    logic [17:0] s7_base;
    assign s7_yoe  = st_reg[6].yoe;
    assign s7_c100 = 2'(s7_yoe >= 9'd100) + 2'(s7_yoe >= 9'd200) + 2'(s7_yoe >= 9'd300);
    assign s7_base = 18'(s7_yoe) * 18'(DAYS_PER_YEAR) + 18'(s7_yoe[8:2]) - 18'(s7_c100);

    // Stage 8: shifted month estimate
    logic [10:0] s8_mx;
    logic [14:0] s8_prod;
    assign s8_mx   = 11'({st_reg[7].doy, 2'b00}) + 11'(st_reg[7].doy) + 11'd2;
    assign s8_prod = 15'(s8_mx) * 15'(MP_RECIP);

    // Stage 9: fix shifted month
    logic [10:0] s9_r;
    assign s9_r = st_reg[8].mx - 11'(st_reg[8].mp_est) * 11'(DAYS_PER_5MONTHS);

    // Stage 10: civil day, month, year
    logic [3:0] s10_month;
    assign s10_month = (st_reg[9].mp < 4'(MARCH_MONTHS))
                       ? st_reg[9].mp + 4'(MONTH_OFS_UP)
                       : st_reg[9].mp - 4'(MONTH_OFS_DOWN);

    // Per-stage next values
    always_comb
    begin
        st_next[0]          = '0;
        st_next[0].t        = stamp.epoch_seconds;
        st_next[0].days_est = s0_prod[40:25];

        st_next[1]          = st_reg[0];
        st_next[1].days     = st_reg[0].days_est + 16'(s1_fix);
        st_next[1].sod      = {s1_rfix[9:0], st_reg[0].t[DAY_LO_BITS-1:0]};

        st_next[2]          = st_reg[1];
        st_next[2].era5     = s2_era5;
        st_next[2].doe      = s2_doe[17:0];
        st_next[2].wd_est   = s2_wd_prod[29:16];
        st_next[2].hour_est = s2_hr_prod[22:17];

        st_next[3]          = st_reg[2];
        st_next[3].q4y_est  = s3_q_prod[25:18];
        st_next[3].cent     = 3'(s3_doe >= 18'(DAYS_PER_100Y))
                              + 3'(s3_doe >= 18'(2 * DAYS_PER_100Y))
                              + 3'(s3_doe >= 18'(3 * DAYS_PER_100Y))
                              + 3'(s3_doe >= 18'(4 * DAYS_PER_100Y));
        st_next[3].last     = s3_doe == 18'(LAST_DAY_OF_ERA);
        st_next[3].weekday  = (s3_wd_r >= 16'(DAYS_PER_WEEK))
                              ? 3'(s3_wd_r - 16'(DAYS_PER_WEEK)) : 3'(s3_wd_r);
        st_next[3].hour     = 5'(st_reg[2].hour_est + 6'(s3_hr_fix));
        st_next[3].rem      = s3_hr_fix ? 12'(s3_hr_r - 17'(SECS_PER_HOUR)) : 12'(s3_hr_r);

        st_next[4]          = st_reg[3];
        st_next[4].n        = st_reg[3].doe - 18'(s4_q4y) + 18'(st_reg[3].cent)
                              - 18'(st_reg[3].last);
        st_next[4].min_est  = s4_min_prod[18:12];

        st_next[5]          = st_reg[4];
        st_next[5].yoe_est  = s5_yoe_prod[27:18];
        st_next[5].minute   = 6'(st_reg[4].min_est + 7'(s5_min_fix));
        st_next[5].second   = s5_min_fix ? 6'(s5_min_r - 12'(SECS_PER_MINUTE))
                                         : 6'(s5_min_r);

        st_next[6]          = st_reg[5];
        st_next[6].yoe      = 9'(st_reg[5].yoe_est + 10'(s6_r >= 18'(DAYS_PER_YEAR)));

        st_next[7]          = st_reg[6];
        st_next[7].doy      = 9'(st_reg[6].doe - s7_base);

        st_next[8]          = st_reg[7];
        st_next[8].mx       = s8_mx;
        st_next[8].mp_est   = s8_prod[14:11];

        st_next[9]          = st_reg[8];
        st_next[9].mp       = st_reg[8].mp_est + 4'(s9_r >= 11'(DAYS_PER_5MONTHS));

        st_next[10]         = st_reg[9];
        st_next[10].month   = s10_month;
        st_next[10].day     = 5'(st_reg[9].doy - month_start(st_reg[9].mp) + 9'd1);
        st_next[10].year    = 12'(st_reg[9].yoe)
                              + (st_reg[9].era5 ? 12'(ERA5_YEAR) : 12'(ERA4_YEAR))
                              + 12'(s10_month <= 4'(FEBRUARY));
    end

    // Backpressure: a stage moves when it is empty or the next one moves
    assign stage_rdy[NUM_STAGES] = date.ready;
    genvar g;
    generate
        for (g = 0; g < NUM_STAGES; g++)
        begin : g_rdy
            assign stage_rdy[g] = !vld_reg[g] || stage_rdy[g+1];
        end
    endgenerate

    assign vld_in = {vld_reg[NUM_STAGES-2:0], stamp.valid};

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                if (stage_rdy[i])
                begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (stage_rdy[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // Channel outputs
    assign stamp.ready  = stage_rdy[0];
    assign date.valid   = vld_reg[LAST];
    assign date.year    = st_reg[LAST].year;
    assign date.month   = st_reg[LAST].month;
    assign date.day     = st_reg[LAST].day;
    assign date.weekday = st_reg[LAST].weekday;
    assign date.hour    = st_reg[LAST].hour;
    assign date.minute  = st_reg[LAST].minute;
    assign date.second  = st_reg[LAST].second;

endmodule

`default_nettype wire
